FILE: hdl/rbd_pkg.sv
// Shared types and constants for the run-length byte decompressor.
package rbd_pkg;

   localparam int LEN_BITS_DEF   = 24;
   localparam int PACK_BYTES_DEF = 8;

   localparam int DATA_W      = 8;
   localparam int LIMIT_W     = 24;
   localparam int TOTAL_W     = 24;
   localparam int COUNT_W     = 4;
   localparam int WORD_BYTES  = 8;
   localparam int WORD_W      = WORD_BYTES * DATA_W;
   localparam int RUN_W       = 8;
   localparam int RSP_TDATA_W = 96;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};
   localparam logic [RUN_W-1:0]   REP_MIN     = RUN_W'(3);

   localparam int FIFO_DEPTH = 4;

   // one parsed command: a run of count copies of data (count 0: no bytes)
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [RUN_W-1:0]  count;
      logic              last;
   } cmd_type;

endpackage

FILE: hdl/rle_byte_decompressor.sv
// Top level of the packbits-style run-length byte decompressor.
// Usage:
//   req_* carries one compressed byte per word (req_tlast ends the stream).
//   rsp_* carries up to PACK_BYTES decompressed bytes per word, with the byte
//   count, a run-end flag, the stream total so far and, on rsp_tlast, the end
//   of the stream.
//   csr_wen/csr_wdata set the per-stream output limit; write it only while idle.
// Timing:
//   An accepted byte lands in a four-entry command queue; its first result
//   word then passes the expander's command registers and output register.
//   The expander loads a command, then emits one result word per cycle while
//   the output is free; a repeat run of n bytes makes ceil(n/PACK_BYTES) words.
//   Control bytes never reach the expander unless last.
//   Input is taken whenever the queue has room.
// Reset clears the parser, the queue, the byte count and the output valid flag,
// and sets the limit to its maximum.
// A stall on rsp_tready holds the output word, then backs up the queue and
// finally drops req_tready.
module rle_byte_decompressor
   import rbd_pkg::*;
#(
   parameter int LEN_BITS   = LEN_BITS_DEF,
   parameter int PACK_BYTES = PACK_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // in_byte
   input  logic                   req_tlast,   // stream_last
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_bytes, byte_count, run_end, total_out
   output logic                   rsp_tlast,   // stream_done
   input  logic                   csr_wen,
   input  logic [LIMIT_W-1:0]     csr_wdata    // output_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic               q_push, q_full, q_pop, q_empty;
   cmd_type            push_cmd, head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wen) begin
         limit_ff <= csr_wdata;
      end
   end

   rbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   rbd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   rbd_back #(
      .LEN_BITS   (LEN_BITS),
      .PACK_BYTES (PACK_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .output_limit (limit_ff),
      .q_empty      (q_empty),
      .q_cmd        (head_cmd),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

FILE: hdl/rbd_front.sv
// Front end: parses compressed bytes into run commands.
module rbd_front
   import rbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output cmd_type           q_cmd
);

   typedef enum logic [2:0] {
      PH_CTRL = 3'b001,
      PH_LIT  = 3'b010,
      PH_REP  = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [6:0] lit_left_ff, lit_left_in;
   logic [6:0] rep_len_ff, rep_len_in;
   logic       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      phase_in    = phase_ff;
      lit_left_in = lit_left_ff;
      rep_len_in  = rep_len_ff;
      q_push      = 1'b0;
      q_cmd.data  = req_tdata;
      q_cmd.count = '0;
      q_cmd.last  = req_tlast;
      if (accept) begin
         case (phase_ff)
            PH_LIT: begin
               q_push      = 1'b1;
               q_cmd.count = RUN_W'(1);
               if (lit_left_ff == '0) begin
                  phase_in = PH_CTRL;
               end else begin
                  lit_left_in = lit_left_ff - 7'd1;
               end
            end
            PH_REP: begin
               q_push      = 1'b1;
               q_cmd.count = RUN_W'(rep_len_ff) + REP_MIN;
               phase_in    = PH_CTRL;
            end
            default: begin
               // control byte; only the stream's last one makes a result
               q_push = req_tlast;
               if (req_tdata[7]) begin
                  rep_len_in = req_tdata[6:0];
                  phase_in   = PH_REP;
               end else begin
                  lit_left_in = req_tdata[6:0];
                  phase_in    = PH_LIT;
               end
            end
         endcase
         if (req_tlast) begin
            phase_in    = PH_CTRL;
            lit_left_in = '0;
            rep_len_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CTRL;
         lit_left_ff <= '0;
         rep_len_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         lit_left_ff <= lit_left_in;
         rep_len_ff  <= rep_len_in;
      end
   end

endmodule

FILE: hdl/rbd_fifo.sv
// Small command queue between the parser and the expander.
module rbd_fifo
   import rbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(FIFO_DEPTH));
   assign empty    = (fill_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: hdl/rbd_back.sv
// Back end: clamps runs to the output limit and packs bytes into result words.
module rbd_back
   import rbd_pkg::*;
#(
   parameter int LEN_BITS   = LEN_BITS_DEF,
   parameter int PACK_BYTES = PACK_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LIMIT_W-1:0]     output_limit,
   input  logic                   q_empty,
   input  cmd_type                q_cmd,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int WIDE_W = (LEN_BITS > LIMIT_W) ? LEN_BITS : LIMIT_W;
   localparam int SUM_W  = (WIDE_W > TOTAL_W) ? WIDE_W : TOTAL_W;
   localparam int PAD_W  = RSP_TDATA_W - (WORD_W + COUNT_W + 1 + TOTAL_W);

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [LEN_BITS-1:0]   written_ff, written_in;
   logic [RUN_W-1:0]      rem_ff, rem_in;
   logic [DATA_W-1:0]     byte_ff, byte_in;
   logic                  last_ff, last_in;

   logic                  valid_ff, valid_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  run_end_ff, run_end_in;
   logic                  done_ff, done_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;

   logic [WIDE_W-1:0]     lim_wide, mask_wide, lim_sat;
   logic [LEN_BITS-1:0]   lim, room, run_len;
   logic [RUN_W-1:0]      clamp_cnt;
   logic [COUNT_W-1:0]    take;
   logic [LEN_BITS-1:0]   sum;
   logic                  out_free, final_word;
   logic [WORD_W-1:0]     packed_word;

   // limit saturated to the width of the byte counter
   always_comb begin
      lim_wide  = WIDE_W'(output_limit);
      mask_wide = WIDE_W'({LEN_BITS{1'b1}});
      lim_sat   = (lim_wide > mask_wide) ? mask_wide : lim_wide;
      lim       = lim_sat[LEN_BITS-1:0];
      room      = (written_ff < lim) ? lim - written_ff : '0;
      run_len   = LEN_BITS'(q_cmd.count);
      clamp_cnt = (room < run_len) ? room[RUN_W-1:0] : q_cmd.count;
   end

   always_comb begin
      take       = (rem_ff < RUN_W'(PACK_BYTES)) ? rem_ff[COUNT_W-1:0]
                                                 : COUNT_W'(PACK_BYTES);
      final_word = (rem_ff == RUN_W'(take));
      sum        = written_ff + LEN_BITS'(take);
      for (int i = 0; i < WORD_BYTES; i++) begin
         packed_word[DATA_W*i +: DATA_W] =
            ((i < PACK_BYTES) && (i < int'(take))) ? byte_ff : '0;
      end
   end

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      written_in = written_ff;
      rem_in     = rem_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      q_pop      = 1'b0;
      valid_in   = out_free ? 1'b0 : valid_ff;
      word_in    = word_ff;
      count_in   = count_ff;
      run_end_in = run_end_ff;
      done_in    = done_ff;
      total_in   = total_ff;
      case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               // a clamped-away run only speaks when it closes the stream
               if ((clamp_cnt != '0) || q_cmd.last) begin
                  rem_in   = clamp_cnt;
                  byte_in  = q_cmd.data;
                  last_in  = q_cmd.last;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               valid_in   = 1'b1;
               word_in    = packed_word;
               count_in   = take;
               run_end_in = final_word;
               done_in    = final_word && last_ff;
               total_in   = TOTAL_W'(SUM_W'(sum));
               rem_in     = rem_ff - RUN_W'(take);
               written_in = (final_word && last_ff) ? '0 : sum;
               if (final_word) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         written_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         written_ff <= written_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      word_ff    <= word_in;
      count_ff   <= count_in;
      run_end_ff <= run_end_in;
      done_ff    <= done_in;
      total_ff   <= total_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = done_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, total_ff, run_end_ff, count_ff, word_ff};

endmodule
